// File: hdl/fbc32_pkg.sv
// shared types, constants and functions of the 32-bit feistel block cipher
package fbc32_pkg;

	localparam int NUM_ROUNDS_DEF = 4;
	localparam int HALF_W = 16;
	localparam int BLOCK_W = 32;
	localparam int KEY_W = 64;

	typedef enum logic {
		KIND_ENCRYPT = 1'b0,
		KIND_DECRYPT = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [HALF_W-1:0] left;
		logic [HALF_W-1:0] right;
	} stage_t;

	localparam logic [3:0] SBOX [16] = '{
		4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
		4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
	};

	// zero-based destination of each bit
	localparam logic [3:0] PERM [16] = '{
		4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
		4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
	};

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] amt);
		logic [63:0] tmp;
		tmp = {v, v} << amt;
		return tmp[63:32];
	endfunction

	function automatic logic [HALF_W-1:0] round_key(input logic [KEY_W-1:0] mkey,
		input logic [1:0] r);
		logic [31:0] t;
		logic [4:0]  amt;
		logic [2:0]  rnum;
		if (r < 2'd2) begin
			amt = 5'd3 + {2'b00, r, 1'b0};
			t = rotl32(mkey[63:32], amt);
		end else begin
			amt = 5'd7 + {2'b00, r - 2'd2, 1'b0};
			t = rotl32(mkey[31:0], amt);
		end
		rnum = {1'b0, r} + 3'd1;
		t = t ^ {29'd0, rnum};
		return t[HALF_W-1:0];
	endfunction

	function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] x,
		input logic [HALF_W-1:0] k);
		logic [HALF_W-1:0] s;
		logic [HALF_W-1:0] p;
		for (int i = 0; i < 4; i++) begin
			s[4*i +: 4] = SBOX[x[4*i +: 4]];
		end
		p = '0;
		for (int i = 0; i < HALF_W; i++) begin
			p[PERM[i]] = s[i];
		end
		return p + k;
	endfunction

endpackage

// File: hdl/feistel_block_cipher_32_core.sv
// top level of the 32-bit feistel block cipher: key register and chain of round cells
// each transaction passes through the chain of round cells, one registered round per cell
// throughput: one block per cycle while m_tready holds; each cell holds one block and stalls only when full
// and its successor is stalled, so a waiting result blocks input only once all cells are full
// reset: clears all cell valid flags and sets the master key to zero
// the master key may only be written while no block is in flight
module feistel_block_cipher_32_core #(
	parameter int NUM_ROUNDS = fbc32_pkg::NUM_ROUNDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fbc32_pkg::KEY_W-1:0]   cfg_wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fbc32_pkg::BLOCK_W-1:0] s_tdata,  // block_in
	input  logic                          s_tuser,  // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fbc32_pkg::BLOCK_W-1:0] m_tdata   // block_out
);

	logic [fbc32_pkg::KEY_W-1:0]                   master_key_q;
	logic [NUM_ROUNDS-1:0][fbc32_pkg::HALF_W-1:0] round_keys;
	logic [NUM_ROUNDS:0]                           valid;
	logic [NUM_ROUNDS:0]                           ready;
	fbc32_pkg::stage_t                             data [NUM_ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_key_q <= '0;
		end else if (cfg_wr_en) begin
			master_key_q <= cfg_wr_data;
		end
	end

	fbc32_key_sched #(
		.NUM_ROUNDS(NUM_ROUNDS)
	) u_key_sched (
		.master_key(master_key_q),
		.round_keys(round_keys)
	);

	assign valid[0]      = s_tvalid;
	assign s_tready      = ready[0];
	assign data[0].kind  = fbc32_pkg::kind_t'(s_tuser);
	assign data[0].left  = s_tdata[fbc32_pkg::BLOCK_W-1:fbc32_pkg::HALF_W];
	assign data[0].right = s_tdata[fbc32_pkg::HALF_W-1:0];

	for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
		fbc32_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid[g]),
			.in_ready (ready[g]),
			.in_data  (data[g]),
			.key_enc  (round_keys[g]),
			.key_dec  (round_keys[NUM_ROUNDS-1-g]),
			.out_valid(valid[g+1]),
			.out_ready(ready[g+1]),
			.out_data (data[g+1])
		);
	end

	assign ready[NUM_ROUNDS] = m_tready;
	assign m_tvalid          = valid[NUM_ROUNDS];
	assign m_tdata           = {data[NUM_ROUNDS].left, data[NUM_ROUNDS].right};

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> &valid[NUM_ROUNDS:1])
		else $error("input stalled while a round cell is empty");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!(|valid[NUM_ROUNDS:1]) |-> s_tready)
		else $error("empty chain refuses input");

	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid[1])
		else $error("accepted transaction lost in first round cell");

endmodule

// File: hdl/fbc32_key_sched.sv
// round key derivation from the master key register
module fbc32_key_sched #(
	parameter int NUM_ROUNDS = fbc32_pkg::NUM_ROUNDS_DEF
) (
	input  logic [fbc32_pkg::KEY_W-1:0]                   master_key,
	output logic [NUM_ROUNDS-1:0][fbc32_pkg::HALF_W-1:0] round_keys
);

	for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_key
		assign round_keys[g] = fbc32_pkg::round_key(master_key, 2'(g));
	end

endmodule

// File: hdl/fbc32_round_cell.sv
// one feistel round with its pipeline register and flow control
module fbc32_round_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  fbc32_pkg::stage_t            in_data,
	input  logic [fbc32_pkg::HALF_W-1:0] key_enc,
	input  logic [fbc32_pkg::HALF_W-1:0] key_dec,
	output logic                         out_valid,
	input  logic                         out_ready,
	output fbc32_pkg::stage_t            out_data
);

	logic              valid_q;
	fbc32_pkg::stage_t data_q;
	fbc32_pkg::stage_t data_d;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		data_d.kind = in_data.kind;
		if (in_data.kind == fbc32_pkg::KIND_ENCRYPT) begin
			data_d.left  = in_data.right;
			data_d.right = in_data.left ^ fbc32_pkg::round_fn(in_data.right, key_enc);
		end else begin
			data_d.left  = in_data.right ^ fbc32_pkg::round_fn(in_data.left, key_dec);
			data_d.right = in_data.left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= data_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: test/feistel_result_checker.sv
// checker for the 32-bit feistel block cipher: predicts each output block and compares it
module feistel_result_checker #(
	parameter int ROUNDS = fbc32_pkg::NUM_ROUNDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fbc32_pkg::KEY_W-1:0]   cfg_wr_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [fbc32_pkg::BLOCK_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [fbc32_pkg::BLOCK_W-1:0] m_tdata,
	output int                            outstanding,
	output int                            fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// s-box entry n sits in bits 4n+3..4n
	localparam logic [63:0] SBOX_PACKED = 64'h7095_C6A3_8BF2_1D4E;

	logic [fbc32_pkg::BLOCK_W-1:0] expected_blocks [$];
	logic [fbc32_pkg::KEY_W-1:0]   master_key;
	int                            mismatches;

	function automatic logic [31:0] rotate_left(input logic [31:0] v, input int amt);
		amt = amt % 32;
		if (amt == 0) begin
			return v;
		end
		return (v << amt) | (v >> (32 - amt));
	endfunction

	function automatic logic [fbc32_pkg::HALF_W-1:0] feistel_key(
		input logic [fbc32_pkg::KEY_W-1:0] key, input int r);
		logic [31:0] w;
		if (r < 2) begin
			w = rotate_left(key[63:32], 3 + 2 * r);
		end else begin
			w = rotate_left(key[31:0], 7 + 2 * (r - 2));
		end
		w = w ^ (r + 1);
		return w[fbc32_pkg::HALF_W-1:0];
	endfunction

	function automatic logic [fbc32_pkg::HALF_W-1:0] feistel_round(
		input logic [fbc32_pkg::HALF_W-1:0] x, input logic [fbc32_pkg::HALF_W-1:0] k);
		logic [fbc32_pkg::HALF_W-1:0] s;
		logic [fbc32_pkg::HALF_W-1:0] p;
		for (int i = 0; i < 4; i++) begin
			s[4*i +: 4] = SBOX_PACKED[4 * x[4*i +: 4] +: 4];
		end
		// bit i goes to 4*(i mod 4) + i/4
		p = '0;
		for (int i = 0; i < fbc32_pkg::HALF_W; i++) begin
			p[4 * (i % 4) + i / 4] = s[i];
		end
		return p + k;
	endfunction

	function automatic logic [fbc32_pkg::BLOCK_W-1:0] feistel_transform(
		input fbc32_pkg::kind_t op, input logic [fbc32_pkg::BLOCK_W-1:0] blk,
		input logic [fbc32_pkg::KEY_W-1:0] key);
		logic [fbc32_pkg::HALF_W-1:0] left;
		logic [fbc32_pkg::HALF_W-1:0] right;
		logic [fbc32_pkg::HALF_W-1:0] t;
		left = blk[31:16];
		right = blk[15:0];
		if (op == fbc32_pkg::KIND_ENCRYPT) begin
			for (int r = 0; r < ROUNDS; r++) begin
				t = right;
				right = left ^ feistel_round(right, feistel_key(key, r));
				left = t;
			end
		end else begin
			for (int r = ROUNDS; r > 0; r--) begin
				t = left;
				left = right ^ feistel_round(left, feistel_key(key, r - 1));
				right = t;
			end
		end
		return {left, right};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [fbc32_pkg::BLOCK_W-1:0] want;
		if (!arst_n) begin
			expected_blocks.delete();
			master_key = '0;
			mismatches = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_blocks.push_back(feistel_transform(fbc32_pkg::kind_t'(s_tuser),
					s_tdata, master_key));
			end
			if (m_tvalid && m_tready) begin
				if (expected_blocks.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result transaction, block_out %h",
							$realtime, m_tdata);
					end
				end else begin
					want = expected_blocks.pop_front();
					if (m_tdata !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: block_out mismatch, expected %h, got %h",
								$realtime, want, m_tdata);
						end
					end
				end
			end
			if (cfg_wr_en) begin
				master_key = cfg_wr_data;
			end
			outstanding <= expected_blocks.size();
			fail_count <= mismatches;
		end
	end

endmodule

// File: test/testbench.sv
// top of the 32-bit feistel block cipher testbench: clock, reset, stimulus and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = fbc32_pkg::NUM_ROUNDS_DEF;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [fbc32_pkg::KEY_W-1:0]   cfg_wr_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [fbc32_pkg::BLOCK_W-1:0] s_tdata = '0;
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [fbc32_pkg::BLOCK_W-1:0] m_tdata;
	int                            outstanding;
	int                            fail_count;
	int                            idle_pct = 0;
	int                            stall_pct = 0;

	feistel_block_cipher_32_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	feistel_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.outstanding(outstanding),
		.fail_count (fail_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_block(input fbc32_pkg::kind_t kind,
		input logic [fbc32_pkg::BLOCK_W-1:0] blk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= blk;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic load_key(input logic [fbc32_pkg::KEY_W-1:0] key);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= key;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		logic [fbc32_pkg::BLOCK_W-1:0] edge_blocks [7];
		logic [fbc32_pkg::BLOCK_W-1:0] blk;
		logic [fbc32_pkg::KEY_W-1:0]   key;
		edge_blocks[0] = 32'h0000_0000;
		edge_blocks[1] = 32'hFFFF_FFFF;
		edge_blocks[2] = 32'h0000_FFFF;
		edge_blocks[3] = 32'hFFFF_0000;
		edge_blocks[4] = 32'h8000_0001;
		edge_blocks[5] = 32'h7FFF_FFFE;
		edge_blocks[6] = 32'h1234_5678;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key, both directions on edge-case blocks
		for (int i = 0; i < 7; i++) begin
			send_block(fbc32_pkg::KIND_ENCRYPT, edge_blocks[i]);
			send_block(fbc32_pkg::KIND_DECRYPT, edge_blocks[i]);
		end
		s_tvalid <= 1'b0;
		wait_drained();
		load_key({fbc32_pkg::KEY_W{1'b1}});
		send_block(fbc32_pkg::KIND_ENCRYPT, edge_blocks[0]);
		send_block(fbc32_pkg::KIND_DECRYPT, edge_blocks[1]);
		send_block(fbc32_pkg::KIND_ENCRYPT, edge_blocks[1]);
		send_block(fbc32_pkg::KIND_DECRYPT, edge_blocks[0]);

		for (int c = 0; c < 8; c++) begin
			s_tvalid <= 1'b0;
			wait_drained();
			case (c)
				0: key = {fbc32_pkg::KEY_W{1'b1}};
				1: key = '0;
				3: key = 64'h8000_0000_0000_0001;
				5: key = 64'hAAAA_5555_0F0F_F0F0;
				default: key = {$urandom, $urandom};
			endcase
			load_key(key);
			case (c % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 88; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 88; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			repeat (112) begin
				case ($urandom_range(9))
					0: blk = {16'h0000, 16'($urandom)};
					1: blk = {16'hFFFF, 16'($urandom)};
					2: blk = {16'($urandom), 16'h0000};
					3: blk = {16'($urandom), 16'hFFFF};
					default: blk = $urandom;
				endcase
				send_block(fbc32_pkg::kind_t'($urandom_range(1)), blk);
			end
		end
		s_tvalid <= 1'b0;
		wait_drained();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
